// ===== hw/rtl/ppm_pkg.sv =====
package ppm_pkg;

  localparam int unsigned MAX_DIM_DEFAULT    = 4096;
  localparam int unsigned MAX_SAMPLE_DEFAULT = 65535;
  localparam int unsigned DIM_FIELD_MAX      = 8191;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [25:0] COUNT_MAX = 26'h3FFFFFF;

  typedef enum logic [1:0] {
    EV_SAMPLE = 2'd0,
    EV_HEADER = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_ERROR  = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_DIMS_EXTRA  = 3'd1,
    ERR_ZERO_DIM    = 3'd2,
    ERR_MAXV_EXTRA  = 3'd3,
    ERR_PIXEL_CHAR  = 3'd4,
    ERR_COUNT       = 3'd5,
    ERR_TOO_LARGE   = 3'd6
  } err_t;

  localparam err_t ERR_BAD_MAGIC = ERR_NONE;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_DIMS    = 3'd1,
    PH_COMMENT = 3'd2,
    PH_MAXVAL  = 3'd3,
    PH_PIXELS  = 3'd4,
    PH_HALT    = 3'd5
  } phase_t;

  typedef struct packed {
    logic        is_final;
    err_t        error_code;
    logic [15:0] max_value;
    logic [12:0] height;
    logic [12:0] width;
    logic [15:0] sample_value;
    event_t      event_res;
  } result_t;

endpackage

// ===== hw/rtl/ppm_p3_ascii_parser.sv =====
// PPM P3 header and sample parser.
// The slave channel takes one file byte per word; tlast marks the final byte
// of the file. Each byte is parsed in the cycle it is accepted and its results
// (none, one or two) are written to a four-word result queue, from which they
// are offered on the master channel in the order they were written.
// tuser carries the event kind and tlast marks the last result of a byte.
// The block takes one byte per cycle; the only limit is the result queue,
// which accepts a byte only while it has room for two results, so a stalled
// receiver holds the input off once three or more results are waiting.
// Bytes that give at most one result each sustain one byte per cycle while
// the receiver keeps up. A file can end with a result pair (sample plus
// verdict), sent as two words. After the final byte the parser state returns to
// its reset values, ready for the next file. After an error the rest of the
// file is dropped without results until its final byte.
// Reset empties the result queue and puts the parser at the magic line.
// The product width*height*3 used for the final count check is registered
// every cycle from the stored dimensions, which are stable before any pixel.
module ppm_p3_ascii_parser #(
  parameter int unsigned MAX_DIM    = ppm_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned MAX_SAMPLE = ppm_pkg::MAX_SAMPLE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_req
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // sample_value, width, height, max_value, error_code
  output logic [1:0]  m_axis_tuser,   // event_res
  output logic        m_axis_tlast    // is_final
);

  localparam int unsigned DIM_LIMIT =
    (MAX_DIM < ppm_pkg::DIM_FIELD_MAX) ? MAX_DIM : ppm_pkg::DIM_FIELD_MAX;

  ppm_pkg::phase_t phase, ph;
  logic [1:0]  magic_pos, mpos;
  logic        magic_bad, mbad;
  logic        line_start, ls;
  logic        prev_was_space, pws;
  logic [1:0]  separator_count, sep;
  logic [12:0] width_acc, wa;
  logic [12:0] height_acc, ha;
  logic [15:0] maxval_acc, mv;
  logic [15:0] number_acc, na;
  logic        token_pending, tp;
  logic [25:0] sample_count, sc;
  logic [27:0] need;
  logic [25:0] dim_prod;

  logic        in_fire;
  logic        is_digit, is_space, is_nl;
  logic [3:0]  digit_val;
  logic [15:0] acc_sel;
  logic [19:0] acc_mul, acc_bound;
  logic        acc_ovf;

  ppm_pkg::event_t ev_slot [2];
  logic [15:0]     sv_slot [2];
  ppm_pkg::err_t   ec_slot [2];
  logic [1:0]      n_res;
  ppm_pkg::result_t res0, res1;

  ppm_pkg::result_t res_q [ppm_pkg::RES_DEPTH];
  logic [ppm_pkg::RES_AW-1:0] wr_ptr, rd_ptr;
  logic [ppm_pkg::RES_AW:0]   count, count_next;
  logic                       pop;
  logic [1:0]                 push_n;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (count <= (ppm_pkg::RES_AW + 1)'(ppm_pkg::RES_DEPTH - 2));

  assign is_digit  = (s_axis_tdata >= ppm_pkg::CH_0) && (s_axis_tdata <= ppm_pkg::CH_9);
  assign is_space  = (s_axis_tdata == ppm_pkg::CH_SPACE);
  assign is_nl     = (s_axis_tdata == ppm_pkg::CH_NL);
  assign digit_val = 4'(s_axis_tdata - ppm_pkg::CH_0);

  always_comb begin
    unique case (phase)
      ppm_pkg::PH_DIMS:   acc_sel = (separator_count == 2'd0) ? {3'b0, width_acc}
                                                              : {3'b0, height_acc};
      ppm_pkg::PH_MAXVAL: acc_sel = maxval_acc;
      default:            acc_sel = number_acc;
    endcase
  end

  assign acc_mul   = {1'b0, acc_sel, 3'b0} + {3'b0, acc_sel, 1'b0} + {16'b0, digit_val};
  assign acc_bound = (phase == ppm_pkg::PH_DIMS) ? 20'(DIM_LIMIT) : 20'(MAX_SAMPLE);
  assign acc_ovf   = (acc_mul > acc_bound);

  // One byte: character handling, then line end (newline or final byte),
  // then the final check.
  always_comb begin
    ph   = phase;
    mpos = magic_pos;
    mbad = magic_bad;
    ls   = line_start;
    pws  = prev_was_space;
    sep  = separator_count;
    wa   = width_acc;
    ha   = height_acc;
    mv   = maxval_acc;
    na   = number_acc;
    tp   = token_pending;
    sc   = sample_count;
    n_res = 2'd0;
    for (int i = 0; i < 2; i++) begin
      ev_slot[i] = ppm_pkg::EV_SAMPLE;
      sv_slot[i] = 16'd0;
      ec_slot[i] = ppm_pkg::ERR_NONE;
    end

    if (ph != ppm_pkg::PH_HALT && !is_nl) begin
      unique case (ph)
        ppm_pkg::PH_MAGIC: begin
          if (mpos >= 2'd2 ||
              s_axis_tdata != ((mpos == 2'd0) ? ppm_pkg::CH_P : ppm_pkg::CH_3)) begin
            mbad = 1'b1;
          end
          if (mpos < 2'd3) begin
            mpos = mpos + 2'd1;
          end
        end
        ppm_pkg::PH_DIMS: begin
          if (ls && s_axis_tdata == ppm_pkg::CH_HASH) begin
            ph = ppm_pkg::PH_COMMENT;
          end else if (sep >= 2'd2) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_DIMS_EXTRA;
            n_res = n_res + 2'd1;
            ph = ppm_pkg::PH_HALT;
          end else if (is_digit) begin
            if (acc_ovf) begin
              ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
              ec_slot[n_res[0]] = ppm_pkg::ERR_TOO_LARGE;
              n_res = n_res + 2'd1;
              ph = ppm_pkg::PH_HALT;
            end else if (sep == 2'd0) begin
              wa = acc_mul[12:0];
            end else begin
              ha = acc_mul[12:0];
            end
          end else if (is_space && !ls && !pws) begin
            sep = sep + 2'd1;
          end
        end
        ppm_pkg::PH_MAXVAL: begin
          if (sep >= 2'd1) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_MAXV_EXTRA;
            n_res = n_res + 2'd1;
            ph = ppm_pkg::PH_HALT;
          end else if (is_digit) begin
            if (acc_ovf) begin
              ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
              ec_slot[n_res[0]] = ppm_pkg::ERR_TOO_LARGE;
              n_res = n_res + 2'd1;
              ph = ppm_pkg::PH_HALT;
            end else begin
              mv = acc_mul[15:0];
            end
          end else if (is_space && !ls && !pws) begin
            sep = sep + 2'd1;
          end
        end
        ppm_pkg::PH_PIXELS: begin
          if (is_digit) begin
            if (acc_ovf) begin
              ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
              ec_slot[n_res[0]] = ppm_pkg::ERR_TOO_LARGE;
              n_res = n_res + 2'd1;
              ph = ppm_pkg::PH_HALT;
            end else begin
              na = acc_mul[15:0];
              tp = 1'b1;
            end
          end else if (is_space) begin
            if (tp) begin
              ev_slot[n_res[0]] = ppm_pkg::EV_SAMPLE;
              sv_slot[n_res[0]] = na;
              n_res = n_res + 2'd1;
              if (sc != ppm_pkg::COUNT_MAX) begin
                sc = sc + 26'd1;
              end
              na = 16'd0;
              tp = 1'b0;
            end
          end else begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_PIXEL_CHAR;
            n_res = n_res + 2'd1;
            ph = ppm_pkg::PH_HALT;
          end
        end
        default: begin
        end
      endcase
      pws = is_space;
      ls  = 1'b0;
    end

    if (ph != ppm_pkg::PH_HALT && (is_nl || s_axis_tlast)) begin
      unique case (ph)
        ppm_pkg::PH_MAGIC: begin
          if (mbad || mpos != 2'd2) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_BAD_MAGIC;
            n_res = n_res + 2'd1;
            ph = ppm_pkg::PH_HALT;
          end else begin
            ph = ppm_pkg::PH_DIMS;
          end
        end
        ppm_pkg::PH_DIMS: begin
          if (wa == 13'd0 || ha == 13'd0) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_ZERO_DIM;
            n_res = n_res + 2'd1;
            ph = ppm_pkg::PH_HALT;
          end else begin
            ph = ppm_pkg::PH_MAXVAL;
          end
        end
        ppm_pkg::PH_COMMENT: ph = ppm_pkg::PH_DIMS;
        ppm_pkg::PH_MAXVAL: begin
          ev_slot[n_res[0]] = ppm_pkg::EV_HEADER;
          n_res = n_res + 2'd1;
          ph = ppm_pkg::PH_PIXELS;
        end
        ppm_pkg::PH_PIXELS: begin
          if (tp) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_SAMPLE;
            sv_slot[n_res[0]] = na;
            n_res = n_res + 2'd1;
            if (sc != ppm_pkg::COUNT_MAX) begin
              sc = sc + 26'd1;
            end
            na = 16'd0;
            tp = 1'b0;
          end
        end
        default: begin
        end
      endcase
      ls  = 1'b1;
      pws = 1'b0;
      sep = 2'd0;
    end

    if (ph != ppm_pkg::PH_HALT && s_axis_tlast) begin
      unique case (ph)
        ppm_pkg::PH_PIXELS: begin
          if ({2'b0, sc} == need) begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ACCEPT;
          end else begin
            ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
            ec_slot[n_res[0]] = ppm_pkg::ERR_COUNT;
          end
          n_res = n_res + 2'd1;
        end
        ppm_pkg::PH_MAXVAL: begin
          ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
          ec_slot[n_res[0]] = ppm_pkg::ERR_COUNT;
          n_res = n_res + 2'd1;
        end
        default: begin
          ev_slot[n_res[0]] = ppm_pkg::EV_ERROR;
          ec_slot[n_res[0]] = ppm_pkg::ERR_ZERO_DIM;
          n_res = n_res + 2'd1;
        end
      endcase
      ph = ppm_pkg::PH_HALT;
    end
  end

  always_comb begin
    res0.event_res    = ev_slot[0];
    res0.sample_value = sv_slot[0];
    res0.width        = wa;
    res0.height       = ha;
    res0.max_value    = mv;
    res0.error_code   = ec_slot[0];
    res0.is_final     = (n_res == 2'd1);
    res1.event_res    = ev_slot[1];
    res1.sample_value = sv_slot[1];
    res1.width        = wa;
    res1.height       = ha;
    res1.max_value    = mv;
    res1.error_code   = ec_slot[1];
    res1.is_final     = 1'b1;
  end

  assign dim_prod = 26'(width_acc) * 26'(height_acc);

  always_ff @(posedge clk) begin
    need <= {2'b0, dim_prod} + {1'b0, dim_prod, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ppm_pkg::PH_MAGIC;
      magic_pos       <= 2'd0;
      magic_bad       <= 1'b0;
      line_start      <= 1'b1;
      prev_was_space  <= 1'b0;
      separator_count <= 2'd0;
      width_acc       <= 13'd0;
      height_acc      <= 13'd0;
      maxval_acc      <= 16'd0;
      number_acc      <= 16'd0;
      token_pending   <= 1'b0;
      sample_count    <= 26'd0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        phase           <= ppm_pkg::PH_MAGIC;
        magic_pos       <= 2'd0;
        magic_bad       <= 1'b0;
        line_start      <= 1'b1;
        prev_was_space  <= 1'b0;
        separator_count <= 2'd0;
        width_acc       <= 13'd0;
        height_acc      <= 13'd0;
        maxval_acc      <= 16'd0;
        number_acc      <= 16'd0;
        token_pending   <= 1'b0;
        sample_count    <= 26'd0;
      end else begin
        phase           <= ph;
        magic_pos       <= mpos;
        magic_bad       <= mbad;
        line_start      <= ls;
        prev_was_space  <= pws;
        separator_count <= sep;
        width_acc       <= wa;
        height_acc      <= ha;
        maxval_acc      <= mv;
        number_acc      <= na;
        token_pending   <= tp;
        sample_count    <= sc;
      end
    end
  end

  assign push_n     = in_fire ? n_res : 2'd0;
  assign pop        = m_axis_tvalid && m_axis_tready;
  assign count_next = count + (ppm_pkg::RES_AW + 1)'(push_n)
                      - (ppm_pkg::RES_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      res_q[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      res_q[wr_ptr + ppm_pkg::RES_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ppm_pkg::RES_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + ppm_pkg::RES_AW'(1);
      end
      count <= count_next;
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = res_q[rd_ptr].event_res;
  assign m_axis_tlast  = res_q[rd_ptr].is_final;
  assign m_axis_tdata  = {3'b0,
                          res_q[rd_ptr].error_code,
                          res_q[rd_ptr].max_value,
                          res_q[rd_ptr].height,
                          res_q[rd_ptr].width,
                          res_q[rd_ptr].sample_value};

endmodule
